@@ src/spcd_pkg.sv @@
// ----------------------------------------------------------------------------
// spcd_pkg
// Shared types and constants for the serial pin command decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package spcd_pkg;

    localparam int PORT_COUNT  = 3;
    localparam int PORT_W      = 2;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int RESET_SHIFT = 16;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    localparam logic [NIB_W-1:0] NIB_COMMIT    = 4'he;
    localparam logic [NIB_W-1:0] NIB_PORT_BASE = 4'ha;
    localparam logic [NIB_W-1:0] NIB_PORT_LAST = NIB_W'(int'(NIB_PORT_BASE) + PORT_COUNT - 1);

    typedef enum logic {
        CMD_SET    = 1'b0,
        CMD_COMMIT = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [PORT_W-1:0] port;
        logic [BIT_W-1:0]  bit_idx;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PIN   = 3'b010,
        PH_LEVEL = 3'b100
    } t_phase;

endpackage

`default_nettype wire

@@ src/serial_pin_command_decoder_top.sv @@
// ----------------------------------------------------------------------------
// serial_pin_command_decoder_top
// Turns received serial bytes into per-port pin set/reset words.
// ----------------------------------------------------------------------------
// Only the low nibble of each byte counts. Select, pin and level bytes are
// taken one per cycle by the front end while the queue is not full; a level
// byte queues a set or reset bit for the selected port and a commit byte
// queues a commit. The back end takes one command a cycle from a two-entry
// queue while it is not busy; a commit keeps it busy until it has emitted
// one word per port through the single output word register, each waiting
// for that register to be free. Words leave in port order, the last flagged,
// and each pending word clears as it is sent.
`default_nettype none

module serial_pin_command_decoder_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [spcd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [spcd_pkg::PORT_W-1:0]      o_port_index,
    output logic [spcd_pkg::WORD_W-1:0]      o_set_reset_word,
    output logic                             o_last_port
);
    import spcd_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    spcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    spcd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    spcd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_port_index     (o_port_index),
        .o_set_reset_word (o_set_reset_word),
        .o_last_port      (o_last_port)
    );

endmodule

`default_nettype wire

@@ src/spcd_front.sv @@
// ----------------------------------------------------------------------------
// spcd_front
// Takes bytes, tracks the select/pin/level sequence and pushes commands.
// ----------------------------------------------------------------------------
`default_nettype none

module spcd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [spcd_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                       i_full,
    output logic                            o_push,
    output spcd_pkg::t_cmd                  o_cmd
);
    import spcd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [PORT_W-1:0]  r_sel, n_sel;
    logic [NIB_W-1:0]   r_pin, n_pin;
    logic [NIB_W-1:0]   nib;
    logic               accept;

    assign nib     = i_rx_byte[NIB_W-1:0];
    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase       = r_phase;
        n_sel         = r_sel;
        n_pin         = r_pin;
        o_push        = 1'b0;
        o_cmd.kind    = CMD_SET;
        o_cmd.port    = r_sel;
        o_cmd.bit_idx = {1'b0, r_pin};
        if (accept) begin
            case (r_phase)
                PH_PIN: begin
                    n_pin   = nib;
                    n_phase = PH_LEVEL;
                end
                PH_LEVEL: begin
                    // level zero moves the bit into the reset half
                    o_push  = 1'b1;
                    n_phase = PH_IDLE;
                    if (nib == '0) begin
                        o_cmd.bit_idx = {1'b0, r_pin} + BIT_W'(RESET_SHIFT);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (nib == NIB_COMMIT) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_COMMIT;
                    end else if (nib inside {[NIB_PORT_BASE:NIB_PORT_LAST]}) begin
                        n_sel   = PORT_W'(nib - NIB_PORT_BASE);
                        n_phase = PH_PIN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sel   <= '0;
            r_pin   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sel   <= n_sel;
            r_pin   <= n_pin;
        end
    end

endmodule

`default_nettype wire

@@ src/spcd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// spcd_cmd_fifo
// Short command queue between the byte front end and the port back end.
// ----------------------------------------------------------------------------
`default_nettype none

module spcd_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire spcd_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output spcd_pkg::t_cmd      o_cmd,
    output logic                o_empty,
    output logic                o_full
);
    import spcd_pkg::*;

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]     r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ src/spcd_back.sv @@
// ----------------------------------------------------------------------------
// spcd_back
// Holds the pending set/reset words and runs commands from the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spcd_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire spcd_pkg::t_cmd              i_cmd,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [spcd_pkg::PORT_W-1:0]      o_port_index,
    output logic [spcd_pkg::WORD_W-1:0]      o_set_reset_word,
    output logic                             o_last_port
);
    import spcd_pkg::*;

    logic [WORD_W-1:0]  r_pend [PORT_COUNT];
    logic [WORD_W-1:0]  n_pend [PORT_COUNT];
    logic               r_busy, n_busy;
    logic [PORT_W-1:0]  r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic [PORT_W-1:0]  r_out_port;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_last;
    logic               out_free;
    logic               emit;
    logic               idx_last;
    logic               do_set;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = !r_busy && !i_empty;
    assign do_set   = o_pop && (i_cmd.kind == CMD_SET);
    assign emit     = r_busy && out_free;
    assign idx_last = (r_idx == PORT_W'(PORT_COUNT - 1));

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        for (int k = 0; k < PORT_COUNT; k++) begin
            n_pend[k] = r_pend[k];
            if (do_set && i_cmd.port == PORT_W'(k)) begin
                n_pend[k] = r_pend[k] | (WORD_W'(1) << i_cmd.bit_idx);
            end
            // word is cleared as it goes out
            if (emit && r_idx == PORT_W'(k)) begin
                n_pend[k] = '0;
            end
        end
        if (o_pop && i_cmd.kind == CMD_COMMIT) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 1'b1;
            if (idx_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_port <= r_idx;
            r_out_word <= r_pend[r_idx];
            r_out_last <= idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < PORT_COUNT; k++) begin
                r_pend[k] <= '0;
            end
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            for (int k = 0; k < PORT_COUNT; k++) begin
                r_pend[k] <= n_pend[k];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_port_index     = r_out_port;
    assign o_set_reset_word = r_out_word;
    assign o_last_port      = r_out_last;

    a_commit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == CMD_COMMIT) |=> (r_busy && r_idx == '0))
        else $error("commit did not start at port zero");

    a_commit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && idx_last) |=> (!r_busy && r_out_valid && r_out_last))
        else $error("commit run did not end on the last port");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= PORT_W'(PORT_COUNT - 1)))
        else $error("port counter out of range");

    a_last_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_port == PORT_W'(PORT_COUNT - 1)))
        else $error("last flag on wrong port");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives received bytes into the pin command decoder under random idling
// and back-pressure, and checks every emitted set/reset word in order
// against a cycle-free model of the select, pin, level and commit decoding.
// ----------------------------------------------------------------------------

module tb;

    import spcd_pkg::*;

    localparam int TOTAL_ITEMS = 480;
    localparam int TAIL_ITEMS  = 60;
    localparam int DIR_N       = 23;
    localparam int HOLD_CYCLES = 300;

    typedef logic [PORT_COUNT-1:0][WORD_W-1:0] t_port_words;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_port_word;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        t_port_words       words;  // element 0 is the rightmost
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_valid;
    logic                 i_ready;
    logic [PORT_W-1:0]    o_port_index;
    logic [WORD_W-1:0]    o_set_reset_word;
    logic                 o_last_port;

    // decoder model state
    t_phase               cmd_phase    = PH_IDLE;
    logic [PORT_W-1:0]    cmd_port     = '0;
    logic [NIB_W-1:0]     cmd_pin      = '0;
    t_port_words          port_pending = '0;

    t_port_word           due_words [$];
    int                   fail_count   = 0;
    int                   sent_count   = 0;
    bit                   steady_tail  = 1'b0;
    bit                   drain_hold   = 1'b0;

    t_step script [0:DIR_N-1] = '{
        '{8'h0e, 1'b1, {32'h0, 32'h0, 32'h0}},          // commit right after reset
        '{8'hfa, 1'b0, '0},                             // port 0, upper bits set
        '{8'h00, 1'b0, '0},                             // pin 0
        '{8'h01, 1'b0, '0},                             // set
        '{8'h0c, 1'b0, '0},                             // last port
        '{8'hff, 1'b0, '0},                             // pin 15
        '{8'hf0, 1'b0, '0},                             // reset, top bit
        '{8'h0e, 1'b1, {32'h8000_0000, 32'h0, 32'h1}},
        '{8'h00, 1'b0, '0},                             // ignored idle nibbles
        '{8'hff, 1'b0, '0},
        '{8'h0d, 1'b0, '0},
        '{8'h39, 1'b0, '0},
        '{8'h0b, 1'b0, '0},
        '{8'h0e, 1'b0, '0},                             // commit nibble as pin
        '{8'h0e, 1'b0, '0},                             // and as a nonzero level
        '{8'h5b, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h0b, 1'b0, '0},                             // same pin set and reset
        '{8'h05, 1'b0, '0},
        '{8'h87, 1'b0, '0},
        '{8'h1e, 1'b0, '0},
        '{8'hee, 1'b1, {32'h0, 32'h0, 32'h0}}           // nothing pending
    };

    serial_pin_command_decoder_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_port_index     (o_port_index),
        .o_set_reset_word (o_set_reset_word),
        .o_last_port      (o_last_port)
    );

    always #2 i_clk = ~i_clk;

    // returns 1 on a commit, with the words that leave
    function automatic bit decode_rx_byte(input logic [BYTE_W-1:0] rx,
                                          output t_port_words words);
        logic [NIB_W-1:0]  nib;
        logic [WORD_W-1:0] pin_bit;
        bit                committed;
        nib       = rx[NIB_W-1:0];
        committed = 1'b0;
        words     = '0;
        case (cmd_phase)
            PH_PIN: begin
                cmd_pin   = nib;
                cmd_phase = PH_LEVEL;
            end
            PH_LEVEL: begin
                pin_bit = WORD_W'(1) << cmd_pin;
                if (nib == '0) begin
                    pin_bit = pin_bit << RESET_SHIFT;
                end
                port_pending[cmd_port] = port_pending[cmd_port] | pin_bit;
                cmd_phase = PH_IDLE;
            end
            default: begin
                cmd_phase = PH_IDLE;
                if (nib == NIB_COMMIT) begin
                    words        = port_pending;
                    port_pending = '0;
                    committed    = 1'b1;
                end else if (nib >= NIB_PORT_BASE && nib <= NIB_PORT_LAST) begin
                    cmd_port  = PORT_W'(nib - NIB_PORT_BASE);
                    cmd_phase = PH_PIN;
                end
            end
        endcase
        return committed;
    endfunction

    task automatic send_rx_byte(input logic [BYTE_W-1:0] rx, input logic typed,
                                input t_port_words typed_words);
        t_port_words words;
        t_port_word  entry;
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (decode_rx_byte(rx, words)) begin
            for (int k = 0; k < PORT_COUNT; k++) begin
                entry.port = PORT_W'(k);
                entry.word = typed ? typed_words[k] : words[k];
                entry.last = (k == PORT_COUNT - 1);
                due_words.push_back(entry);
            end
        end
        sent_count++;
        steady_tail = (sent_count >= TOTAL_ITEMS - TAIL_ITEMS);
    endtask

    task automatic check_word();
        t_port_word want;
        if (due_words.size() == 0) begin
            $error("unexpected word: port %0d word %h last %0b",
                   o_port_index, o_set_reset_word, o_last_port);
            fail_count++;
        end else begin
            want = due_words.pop_front();
            if (o_port_index !== want.port) begin
                $error("port_index: expected %0d, actual %0d", want.port, o_port_index);
                fail_count++;
            end
            if (o_set_reset_word !== want.word) begin
                $error("set_reset_word: expected %h, actual %h",
                       want.word, o_set_reset_word);
                fail_count++;
            end
            if (o_last_port !== want.last) begin
                $error("last_port: expected %0b, actual %0b", want.last, o_last_port);
                fail_count++;
            end
        end
    endtask

    // sender
    initial begin
        int                pick;
        logic [PORT_W-1:0] port;
        logic [NIB_W-1:0]  upper;
        bit                pressed;
        pressed = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_rx_byte(script[i].rx, script[i].typed, script[i].words);
        end

        while (sent_count < TOTAL_ITEMS) begin
            pick  = $urandom_range(0, 99);
            upper = NIB_W'($urandom_range(0, 15));
            if (!pressed && sent_count >= 150) begin
                // stop the receiver and push twelve commits so that the input stalls
                pressed    = 1'b1;
                drain_hold = 1'b1;
                repeat (12) send_rx_byte({NIB_W'($urandom_range(0, 15)), NIB_COMMIT},
                                         1'b0, '0);
            end else if (pick < 12) begin
                send_rx_byte(BYTE_W'($urandom), 1'b0, '0);
            end else if (pick < 30) begin
                send_rx_byte({upper, NIB_COMMIT}, 1'b0, '0);
            end else begin
                port = PORT_W'($urandom_range(0, PORT_COUNT - 1));
                send_rx_byte({upper, NIB_W'(NIB_PORT_BASE + port)}, 1'b0, '0);
                send_rx_byte(BYTE_W'($urandom), 1'b0, '0);
                if ($urandom_range(0, 1) == 0) begin
                    send_rx_byte({NIB_W'($urandom_range(0, 15)), 4'h0}, 1'b0, '0);
                end else begin
                    send_rx_byte(BYTE_W'($urandom), 1'b0, '0);
                end
            end
        end
        i_valid <= 1'b0;

        for (int c = 0; c < 5000 && due_words.size() != 0; c++) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (due_words.size() != 0) begin
            $error("%0d expected words never arrived", due_words.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // receiver
    initial begin
        int  stall_left;
        int  hold_left;
        bit  held;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                check_word();
            end
            if (drain_hold && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ serial_pin_command_decoder_top.f @@
src/spcd_pkg.sv
src/spcd_front.sv
src/spcd_cmd_fifo.sv
src/spcd_back.sv
src/serial_pin_command_decoder_top.sv
test/tb.sv
